// ===== design/aarm_pkg.sv =====
// Shared constants, types and tables for the axis-angle row rotator.
package aarm_pkg;

  localparam int QW = 32;            // Q16.16 data word
  localparam int CW = 36;            // CORDIC datapath
  localparam int SW = 34;            // sine, cosine and 1 - cosine in Q4.30
  localparam int TW = 35;            // (1 - cos) * u terms

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
  localparam int SQRT_BITS    = 32;
  localparam int SQRT_LAT     = SQRT_BITS + 2;
  localparam int DIV_STEPS    = 31;
  localparam int DIV_LAT      = DIV_STEPS + 1;
  localparam int MERGE_LAT    = 6;

  // Stage at which the unit axis leaves the lanes; everything lines up there.
  localparam int U_STAGE   = 2 + SQRT_LAT + DIV_LAT;
  localparam int CS_DLY    = U_STAGE - 1 - CORDIC_LAT;
  localparam int ROW_DLY   = U_STAGE - 1;
  localparam int TOTAL_LAT = U_STAGE + MERGE_LAT;

  localparam logic signed [33:0] ANG_PI      = 34'sd843314857;
  localparam logic signed [33:0] ANG_TWO_PI  = 34'sd1686629713;
  localparam logic signed [33:0] ANG_HALF_PI = 34'sd421657428;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;
  localparam logic signed [SW-1:0] Q30_ONE     = 34'sd1073741824;

  typedef logic signed [QW-1:0] q_t;

  // One row of the matrix plus the zero-axis mark; also the result item.
  typedef struct packed {
    q_t   c0;
    q_t   c1;
    q_t   c2;
    q_t   c3;
    logic zero_axis;
  } res_t;

  function automatic logic [CW-1:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      default: v = 32'h00000000;
    endcase
    return {{(CW-32){1'b0}}, v};
  endfunction

endpackage

// ===== design/aarm_if.sv =====
// Channel interfaces: input rows and result rows with valid/ready.
interface aarm_item_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] angle_rad;
  logic signed [31:0] axis_x;
  logic signed [31:0] axis_y;
  logic signed [31:0] axis_z;
  logic signed [31:0] row_c0;
  logic signed [31:0] row_c1;
  logic signed [31:0] row_c2;
  logic signed [31:0] row_c3;

  modport source (output valid, angle_rad, axis_x, axis_y, axis_z,
                  row_c0, row_c1, row_c2, row_c3, input ready);
  modport sink (input valid, angle_rad, axis_x, axis_y, axis_z,
                row_c0, row_c1, row_c2, row_c3, output ready);
endinterface

interface aarm_result_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] res_c0;
  logic signed [31:0] res_c1;
  logic signed [31:0] res_c2;
  logic signed [31:0] res_c3;
  logic        zero_axis;

  modport source (output valid, res_c0, res_c1, res_c2, res_c3, zero_axis,
                  input ready);
  modport sink (input valid, res_c0, res_c1, res_c2, res_c3, zero_axis,
                output ready);
endinterface

// ===== design/aarm_cordic.sv =====
// Pipelined rotation-mode CORDIC: sine, cosine and 1 - cosine in Q4.30.
module aarm_cordic import aarm_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] z_in,
  input  logic                 neg_in,
  output logic signed [SW-1:0] cos_q,
  output logic signed [SW-1:0] sin_q,
  output logic signed [SW-1:0] t_q
);

  logic signed [CW-1:0] x   [1:CORDIC_STEPS];
  logic signed [CW-1:0] y   [1:CORDIC_STEPS];
  logic signed [CW-1:0] z   [1:CORDIC_STEPS];
  logic                 neg [1:CORDIC_STEPS];
  logic signed [CW-1:0] xf;
  logic signed [CW-1:0] yf;

  genvar i;
  for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CW-1:0] xi;
    logic signed [CW-1:0] yi;
    logic signed [CW-1:0] zi;
    logic                 ni;
    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = z_in;
      assign ni = neg_in;
    end else begin : g_mid
      assign xi = x[i];
      assign yi = y[i];
      assign zi = z[i];
      assign ni = neg[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[CW-1]) begin
          x[i+1] <= xi - (yi >>> i);
          y[i+1] <= yi + (xi >>> i);
          z[i+1] <= zi - $signed(atan_q30(i));
        end else begin
          x[i+1] <= xi + (yi >>> i);
          y[i+1] <= yi - (xi >>> i);
          z[i+1] <= zi + $signed(atan_q30(i));
        end
        neg[i+1] <= ni;
      end
    end
  end

  // Undo the half-turn fold.
  always_comb begin
    xf = neg[CORDIC_STEPS] ? -x[CORDIC_STEPS] : x[CORDIC_STEPS];
    yf = neg[CORDIC_STEPS] ? -y[CORDIC_STEPS] : y[CORDIC_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= xf[SW-1:0];
      sin_q <= yf[SW-1:0];
      t_q   <= Q30_ONE - xf[SW-1:0];
    end
  end

endmodule

// ===== design/aarm_sqrt.sv =====
// Sum of squares and pipelined digit-by-digit integer square root.
module aarm_sqrt import aarm_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] mag [3],
  output logic [31:0] len
);

  logic [63:0] sq   [3];
  logic [63:0] v    [0:SQRT_BITS];
  logic [35:0] rem  [0:SQRT_BITS];
  logic [31:0] root [0:SQRT_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) sq[k] <= mag[k] * mag[k];
      v[0]    <= sq[0] + sq[1] + sq[2];
      rem[0]  <= '0;
      root[0] <= '0;
    end
  end

  genvar j;
  for (j = 0; j < SQRT_BITS; j++) begin : g_digit
    logic [35:0] rem2;
    logic [35:0] trial;
    logic        ge;
    always_comb begin
      rem2  = {rem[j][33:0], v[j][63:62]};
      trial = {2'b00, root[j], 2'b01};
      ge    = rem2 >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= ge ? rem2 - trial : rem2;
        root[j+1] <= {root[j][30:0], ge};
        v[j+1]    <= {v[j][61:0], 2'b00};
      end
    end
  end

  assign len = root[SQRT_BITS];

endmodule

// ===== design/aarm_lane.sv =====
// One axis lane: scaled component times 2^30 divided by length, signed.
module aarm_lane import aarm_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] mag_in,
  input  logic        neg_in,
  input  logic [31:0] len_in,
  output q_t          u
);

  logic [31:0] md  [SQRT_LAT];
  logic        nd  [SQRT_LAT];
  logic [31:0] rem [1:DIV_STEPS];
  logic [30:0] quo [1:DIV_STEPS];
  logic [31:0] dv  [1:DIV_STEPS];
  logic        sg  [1:DIV_STEPS];

  // Hold the component until the length catches up.
  always_ff @(posedge clk) begin
    if (en) begin
      md[0] <= mag_in;
      nd[0] <= neg_in;
      for (int k = 1; k < SQRT_LAT; k++) begin
        md[k] <= md[k-1];
        nd[k] <= nd[k-1];
      end
    end
  end

  genvar i;
  for (i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [31:0] ri;
    logic        bi;
    logic [31:0] di;
    logic [30:0] qi;
    logic        si;
    logic [32:0] r2;
    logic [32:0] diff;
    logic        ge;
    if (i == 0) begin : g_first
      // Upper dividend bits mag[31:1] sit below len, since len >= mag.
      assign ri = {1'b0, md[SQRT_LAT-1][31:1]};
      assign bi = md[SQRT_LAT-1][0];
      assign di = len_in;
      assign qi = '0;
      assign si = nd[SQRT_LAT-1];
    end else begin : g_mid
      assign ri = rem[i];
      assign bi = 1'b0;
      assign di = dv[i];
      assign qi = quo[i];
      assign si = sg[i];
    end
    always_comb begin
      r2   = {ri, bi};
      diff = r2 - {1'b0, di};
      ge   = r2 >= {1'b0, di};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? diff[31:0] : r2[31:0];
        quo[i+1] <= {qi[29:0], ge};
        dv[i+1]  <= di;
        sg[i+1]  <= si;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u <= sg[DIV_STEPS] ? -$signed({1'b0, quo[DIV_STEPS]})
                         : $signed({1'b0, quo[DIV_STEPS]});
    end
  end

endmodule

// ===== design/aarm_merge.sv =====
// Merge: rotation coefficients from the lanes, then the row product.
module aarm_merge import aarm_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [SW-1:0] cos_in,
  input  logic signed [SW-1:0] sin_in,
  input  logic signed [SW-1:0] t_in,
  input  q_t                   u_in [3],
  input  res_t                 row_in,
  output res_t                 res
);

  logic signed [TW-1:0] tt1 [3];
  logic signed [SW-1:0] c1, s1;
  q_t                   u1 [3];
  res_t                 row1, row2, row3, row4, row5;
  logic signed [SW-1:0] pq2 [3][3];
  logic signed [SW-1:0] su2 [3];
  logic signed [SW-1:0] c2;
  q_t                   cf3 [3][3];
  logic signed [63:0]   pr4 [3][3];
  logic signed [63:0]   sm5 [3];
  logic signed [TW-1:0] tt_d [3];
  logic signed [SW-1:0] pq_d [3][3];
  logic signed [SW-1:0] su_d [3];
  q_t                   cf_d [3][3];
  q_t                   rs_d [3];

  function automatic q_t clamp_one(input logic signed [SW:0] v);
    if (v > $signed({1'b0, Q30_ONE})) return 32'sh4000_0000;
    if (v < -$signed({1'b0, Q30_ONE})) return -32'sh4000_0000;
    return v[QW-1:0];
  endfunction

  function automatic q_t round_sat(input logic signed [63:0] v);
    logic signed [64:0] r;
    r = ($signed({v[63], v}) + 65'sd536870912) >>> 30;
    if (r > 65'sd2147483647) return 32'sh7FFF_FFFF;
    if (r < -65'sd2147483648) return 32'sh8000_0000;
    return r[QW-1:0];
  endfunction

  // (1 - cos) scaled by each unit component.
  always_comb begin
    logic signed [65:0] p;
    logic signed [65:0] ps;
    for (int k = 0; k < 3; k++) begin
      p = t_in * u_in[k];
      ps = p >>> 30;
      tt_d[k] = ps[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tt1  <= tt_d;
      c1   <= cos_in;
      s1   <= sin_in;
      u1   <= u_in;
      row1 <= row_in;
    end
  end

  always_comb begin
    logic signed [66:0] p;
    logic signed [66:0] ps;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        p = tt1[a] * u1[b];
        ps = p >>> 30;
        pq_d[a][b] = ps[SW-1:0];
      end
      p = s1 * u1[a];
      ps = p >>> 30;
      su_d[a] = ps[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pq2  <= pq_d;
      su2  <= su_d;
      c2   <= c1;
      row2 <= row1;
    end
  end

  // Diagonal adds cosine; off-diagonal adds or subtracts the sine cross term.
  always_comb begin
    cf_d[0][0] = clamp_one(c2 + pq2[0][0]);
    cf_d[0][1] = clamp_one(pq2[0][1] + su2[2]);
    cf_d[0][2] = clamp_one(pq2[0][2] - su2[1]);
    cf_d[1][0] = clamp_one(pq2[1][0] - su2[2]);
    cf_d[1][1] = clamp_one(c2 + pq2[1][1]);
    cf_d[1][2] = clamp_one(pq2[1][2] + su2[0]);
    cf_d[2][0] = clamp_one(pq2[2][0] + su2[1]);
    cf_d[2][1] = clamp_one(pq2[2][1] - su2[0]);
    cf_d[2][2] = clamp_one(c2 + pq2[2][2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cf3  <= cf_d;
      row3 <= row2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pr4[j][0] <= row3.c0 * cf3[j][0];
        pr4[j][1] <= row3.c1 * cf3[j][1];
        pr4[j][2] <= row3.c2 * cf3[j][2];
      end
      row4 <= row3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) sm5[j] <= pr4[j][0] + pr4[j][1] + pr4[j][2];
      row5 <= row4;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) rs_d[j] = round_sat(sm5[j]);
  end

  // Zero axis: pass the row through untouched.
  always_ff @(posedge clk) begin
    if (en) begin
      res.c0        <= row5.zero_axis ? row5.c0 : rs_d[0];
      res.c1        <= row5.zero_axis ? row5.c1 : rs_d[1];
      res.c2        <= row5.zero_axis ? row5.c2 : rs_d[2];
      res.c3        <= row5.c3;
      res.zero_axis <= row5.zero_axis;
    end
  end

endmodule

// ===== design/axis_angle_rotate_matrix.sv =====
// Top level: streaming axis-angle rotation of 4x4 matrix rows.
//
// One item on the item channel carries one row of a column-major 4x4 matrix
// (row_c0..row_c3, Q16.16), the rotation angle (Q4.28 radians) and the
// rotation axis (Q16.16, any nonzero length). The result channel returns the
// same row of M * R, saturated, with column 3 copied through. An all-zero
// axis sets zero_axis and returns the row unchanged.
//
// Throughput: one item per cycle unless the output buffer is full, with no
// dependence between items. The pipeline depth is set by the axis path: 2
// front-end stages (angle fold, normalizing shift), 34 for the square root
// (squares, sum, 32 digit steps), 32 for the three divider lanes (31 quotient
// steps and the sign), 6 for the merge and one for the output buffer. The
// CORDIC sine/cosine pipeline runs beside it and is delay matched.
//
// Reset (rst, synchronous) empties the pipeline and the output buffer.
// The pipeline advances as a whole; a two-entry output buffer lets the block
// keep taking items while one result waits. When the receiver stalls long
// enough to fill both entries, the pipeline holds and item.ready drops.
module axis_angle_rotate_matrix import aarm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  aarm_item_if.sink     item,
  aarm_result_if.source result
);

  logic                 en;
  logic                 vld [TOTAL_LAT];

  // Stage 1: angle fold, component magnitudes, row capture.
  logic signed [CW-1:0] z1;
  logic                 neg1;
  logic [31:0]          mag1 [3];
  logic                 sgn1 [3];
  res_t                 row1;

  // Stage 2: magnitudes scaled so the largest sits in [2^30, 2^31].
  logic [31:0]          mag2 [3];
  logic                 sgn2 [3];

  logic signed [33:0]   ang;
  logic signed [33:0]   ang_w;
  logic signed [33:0]   ang_f;
  logic                 neg_f;
  logic [31:0]          ax   [3];
  logic [31:0]          mag_d [3];
  logic [31:0]          mx;
  logic [4:0]           sh;

  logic [31:0]          len;
  logic signed [SW-1:0] cos_c, sin_c, t_c;
  logic signed [SW-1:0] cs_cos [CS_DLY];
  logic signed [SW-1:0] cs_sin [CS_DLY];
  logic signed [SW-1:0] cs_t   [CS_DLY];
  res_t                 rl [ROW_DLY];
  q_t                   u [3];
  res_t                 res_m;

  res_t                 head, tail;
  logic [1:0]           count;
  logic                 push, pop;

  function automatic logic [4:0] top_bit(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int b = 0; b < 32; b++) if (v[b]) p = 5'(b);
    return p;
  endfunction

  // Advance unless both output entries are taken.
  assign en         = (count != 2'd2);
  assign item.ready = en;

  // Wrap into [-PI, PI], then fold into [-PI/2, PI/2] and remember the sign.
  always_comb begin
    ang = {{2{item.angle_rad[31]}}, item.angle_rad};
    if (ang > ANG_PI)       ang_w = ang - ANG_TWO_PI;
    else if (ang < -ANG_PI) ang_w = ang + ANG_TWO_PI;
    else                    ang_w = ang;
    neg_f = 1'b1;
    if (ang_w > ANG_HALF_PI)       ang_f = ang_w - ANG_PI;
    else if (ang_w < -ANG_HALF_PI) ang_f = ang_w + ANG_PI;
    else begin
      ang_f = ang_w;
      neg_f = 1'b0;
    end
    ax[0] = item.axis_x;
    ax[1] = item.axis_y;
    ax[2] = item.axis_z;
    for (int k = 0; k < 3; k++) mag_d[k] = ax[k][31] ? ~ax[k] + 32'd1 : ax[k];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1   <= {ang_f, 2'b00};
      neg1 <= neg_f;
      for (int k = 0; k < 3; k++) begin
        mag1[k] <= mag_d[k];
        sgn1[k] <= ax[k][31];
      end
      row1.c0        <= item.row_c0;
      row1.c1        <= item.row_c1;
      row1.c2        <= item.row_c2;
      row1.c3        <= item.row_c3;
      row1.zero_axis <= (item.axis_x == '0) && (item.axis_y == '0) &&
                        (item.axis_z == '0);
    end
  end

  // Normalizing shift: only 2^31 itself has bit 31 set, and it needs none.
  always_comb begin
    mx = mag1[0];
    if (mag1[1] > mx) mx = mag1[1];
    if (mag1[2] > mx) mx = mag1[2];
    sh = mx[31] ? 5'd0 : 5'd30 - top_bit(mx);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag2[k] <= mag1[k] << sh;
        sgn2[k] <= sgn1[k];
      end
    end
  end

  aarm_cordic u_cordic (
    .clk    (clk),
    .en     (en),
    .z_in   (z1),
    .neg_in (neg1),
    .cos_q  (cos_c),
    .sin_q  (sin_c),
    .t_q    (t_c)
  );

  aarm_sqrt u_sqrt (
    .clk (clk),
    .en  (en),
    .mag (mag2),
    .len (len)
  );

  genvar k;
  for (k = 0; k < 3; k++) begin : g_lane
    aarm_lane u_lane (
      .clk    (clk),
      .en     (en),
      .mag_in (mag2[k]),
      .neg_in (sgn2[k]),
      .len_in (len),
      .u      (u[k])
    );
  end

  // Delay lines: hold sine/cosine and the row until the unit axis is ready.
  always_ff @(posedge clk) begin
    if (en) begin
      cs_cos[0] <= cos_c;
      cs_sin[0] <= sin_c;
      cs_t[0]   <= t_c;
      for (int i = 1; i < CS_DLY; i++) begin
        cs_cos[i] <= cs_cos[i-1];
        cs_sin[i] <= cs_sin[i-1];
        cs_t[i]   <= cs_t[i-1];
      end
      rl[0] <= row1;
      for (int i = 1; i < ROW_DLY; i++) rl[i] <= rl[i-1];
    end
  end

  aarm_merge u_merge (
    .clk    (clk),
    .en     (en),
    .cos_in (cs_cos[CS_DLY-1]),
    .sin_in (cs_sin[CS_DLY-1]),
    .t_in   (cs_t[CS_DLY-1]),
    .u_in   (u),
    .row_in (rl[ROW_DLY-1]),
    .res    (res_m)
  );

  // Valid bits follow the items down the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOTAL_LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= item.valid;
      for (int i = 1; i < TOTAL_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // Two-entry output buffer.
  assign push = en && vld[TOTAL_LAT-1];
  assign pop  = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) head <= res_m;
        else               tail <= res_m;
      end
      2'b01: begin
        head <= tail;
      end
      2'b11: begin
        if (count == 2'd1) head <= res_m;
        else begin
          head <= tail;
          tail <= res_m;
        end
      end
      default: begin
        head <= head;
      end
    endcase
  end

  assign result.valid     = (count != 2'd0);
  assign result.res_c0    = head.c0;
  assign result.res_c1    = head.c1;
  assign result.res_c2    = head.c2;
  assign result.res_c3    = head.c3;
  assign result.zero_axis = head.zero_axis;

endmodule

// ===== design/aarm_checker.sv =====
// Port-level checks on the rotator, bound to the top level.
module aarm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_c0,
  input logic [31:0] out_c3,
  input logic        out_zero
);

  // Hold a result until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_c0) && $stable(out_c3) &&
                                $stable(out_zero))
    else $error("result changed while stalled");

  // Reset empties the output buffer.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // With nothing buffered the block must take items.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output buffer");

endmodule

bind axis_angle_rotate_matrix aarm_checker u_aarm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_c0    (result.res_c0),
  .out_c3    (result.res_c3),
  .out_zero  (result.zero_axis)
);
